// File: rtl/rci_pkg.sv
// Shared types, constants and rounding and saturation helpers for the ray and circle intersection block.
package rci_pkg;

  typedef enum logic [1:0] {
    WHERE_INSIDE  = 2'd0,
    WHERE_OUTSIDE = 2'd1,
    WHERE_ON      = 2'd2
  } where_e;

  typedef enum logic [1:0] {
    CFG_RADIUS   = 2'd0,
    CFG_CENTER_X = 2'd1,
    CFG_CENTER_Y = 2'd2
  } cfg_idx_e;

  localparam logic [30:0] RadiusReset = 31'd65536;
  localparam int SqrtSteps = 31;
  localparam int RootW = 31;
  localparam int RadW = 2 * RootW;
  localparam int RemW = RootW + 3;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [34:0] dot;
    logic               ok;
    where_e             where_is;
  } ctx_t;

  function automatic logic signed [34:0] round_q31(input logic signed [49:0] v);
    logic signed [49:0] s;
    s = v + 50'sd16384;
    return s[49:15];
  endfunction

  function automatic logic signed [36:0] round_pt(input logic signed [51:0] v);
    logic signed [51:0] s;
    s = v + 52'sd16384;
    return s[51:15];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -38'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// File: rtl/ray_circle_intersection.sv
// Top level of the ray and circle intersection block with its configuration registers.
// The pipeline has 6 front, 31 root and 3 back stages from input word to result word.
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// The root unit resolves one result bit per stage and sets the depth.
// Reset clears all valid bits and sets radius to 1.0 and the center to the origin.
module ray_circle_intersection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [31:0]        hit_distance_o,
  output logic signed [31:0] hit_x_o,
  output logic signed [31:0] hit_y_o,
  output logic [1:0]         where_is_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_data_i
);

  logic [30:0] radius_q;
  logic signed [31:0] cx_q, cy_q;
  logic en;
  logic f_valid, s_valid;
  rci_pkg::ctx_t f_ctx, s_ctx;
  logic [rci_pkg::RadW-1:0] f_k1;
  logic [rci_pkg::RootW-1:0] s_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rci_pkg::RadiusReset;
      cx_q     <= '0;
      cy_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (rci_pkg::cfg_idx_e'(cfg_addr_i))
        rci_pkg::CFG_RADIUS:   radius_q <= cfg_data_i[30:0];
        rci_pkg::CFG_CENTER_X: cx_q <= cfg_data_i;
        rci_pkg::CFG_CENTER_Y: cy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  rci_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .pos_x_i, .pos_y_i, .dir_x_i, .dir_y_i,
    .radius_i(radius_q), .center_x_i(cx_q), .center_y_i(cy_q),
    .valid_o(f_valid), .ctx_o(f_ctx), .k1_o(f_k1)
  );

  rci_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .ctx_i(f_ctx), .rad_i(f_k1),
    .valid_o(s_valid), .ctx_o(s_ctx), .root_o(s_root)
  );

  rci_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_valid), .ctx_i(s_ctx), .root_i(s_root),
    .valid_o(out_valid_o), .hit_o, .hit_distance_o, .hit_x_o, .hit_y_o, .where_is_o
  );

endmodule

// File: rtl/rci_front.sv
// Front pipeline: offsets, products, cross and dot terms, position relation and root argument.
module rci_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [31:0]       pos_x_i,
  input  logic signed [31:0]       pos_y_i,
  input  logic signed [15:0]       dir_x_i,
  input  logic signed [15:0]       dir_y_i,
  input  logic [30:0]              radius_i,
  input  logic signed [31:0]       center_x_i,
  input  logic signed [31:0]       center_y_i,
  output logic                     valid_o,
  output rci_pkg::ctx_t            ctx_o,
  output logic [rci_pkg::RadW-1:0] k1_o
);

  logic [5:0] v_q;
  logic signed [31:0] px1_q, py1_q, px2_q, py2_q, px3_q, py3_q, px4_q, py4_q, px5_q, py5_q;
  logic signed [15:0] ux1_q, uy1_q, ux2_q, uy2_q, ux3_q, uy3_q, ux4_q, uy4_q, ux5_q, uy5_q;
  logic signed [32:0] dx1_q, dy1_q;
  logic signed [48:0] pc1_q, pc2_q, pd1_q, pd2_q;
  logic [61:0] axx_q, ayy_q, r2_q, cm2_q;
  logic far2_q, far3_q;
  logic signed [34:0] cr3_q, dot3_q, dot4_q, dot5_q;
  logic [62:0] s3_q;
  logic ok4_q, ok5_q;
  rci_pkg::where_e wh4_q, wh5_q;
  logic [30:0] cm4_q;
  logic [32:0] ax, ay;
  logic [34:0] cm;
  rci_pkg::where_e wh_d;
  rci_pkg::ctx_t ctx_q;
  logic [61:0] k1_q;

  assign ax = dx1_q[32] ? 33'(-dx1_q) : 33'(dx1_q);
  assign ay = dy1_q[32] ? 33'(-dy1_q) : 33'(dy1_q);
  assign cm = cr3_q[34] ? 35'(-cr3_q) : 35'(cr3_q);

  always_comb begin
    if (far3_q || (s3_q > {1'b0, r2_q})) begin
      wh_d = rci_pkg::WHERE_OUTSIDE;
    end else if (s3_q < {1'b0, r2_q}) begin
      wh_d = rci_pkg::WHERE_INSIDE;
    end else begin
      wh_d = rci_pkg::WHERE_ON;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= radius_i * radius_i;
    if (en_i) begin
      px1_q <= pos_x_i;
      py1_q <= pos_y_i;
      ux1_q <= dir_x_i;
      uy1_q <= dir_y_i;
      dx1_q <= {center_x_i[31], center_x_i} - {pos_x_i[31], pos_x_i};
      dy1_q <= {center_y_i[31], center_y_i} - {pos_y_i[31], pos_y_i};

      px2_q  <= px1_q;
      py2_q  <= py1_q;
      ux2_q  <= ux1_q;
      uy2_q  <= uy1_q;
      pc1_q  <= ux1_q * dy1_q;
      pc2_q  <= uy1_q * dx1_q;
      pd1_q  <= dx1_q * ux1_q;
      pd2_q  <= dy1_q * uy1_q;
      axx_q  <= ax[30:0] * ax[30:0];
      ayy_q  <= ay[30:0] * ay[30:0];
      far2_q <= (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);

      px3_q  <= px2_q;
      py3_q  <= py2_q;
      ux3_q  <= ux2_q;
      uy3_q  <= uy2_q;
      cr3_q  <= rci_pkg::round_q31({pc1_q[48], pc1_q} - {pc2_q[48], pc2_q});
      dot3_q <= rci_pkg::round_q31({pd1_q[48], pd1_q} + {pd2_q[48], pd2_q});
      s3_q   <= {1'b0, axx_q} + {1'b0, ayy_q};
      far3_q <= far2_q;

      px4_q  <= px3_q;
      py4_q  <= py3_q;
      ux4_q  <= ux3_q;
      uy4_q  <= uy3_q;
      dot4_q <= dot3_q;
      ok4_q  <= cm < {4'd0, radius_i};
      cm4_q  <= cm[30:0];
      wh4_q  <= wh_d;

      px5_q  <= px4_q;
      py5_q  <= py4_q;
      ux5_q  <= ux4_q;
      uy5_q  <= uy4_q;
      dot5_q <= dot4_q;
      ok5_q  <= ok4_q;
      wh5_q  <= wh4_q;
      cm2_q  <= cm4_q * cm4_q;

      ctx_q.px       <= px5_q;
      ctx_q.py       <= py5_q;
      ctx_q.ux       <= ux5_q;
      ctx_q.uy       <= uy5_q;
      ctx_q.dot      <= dot5_q;
      ctx_q.ok       <= ok5_q;
      ctx_q.where_is <= wh5_q;
      k1_q           <= r2_q - cm2_q;
    end
  end

  assign valid_o = v_q[5];
  assign ctx_o   = ctx_q;
  assign k1_o    = k1_q;

endmodule

// File: rtl/rci_sqrt.sv
// Pipelined floor integer square root, one result bit per stage.
module rci_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  rci_pkg::ctx_t             ctx_i,
  input  logic [rci_pkg::RadW-1:0]  rad_i,
  output logic                      valid_o,
  output rci_pkg::ctx_t             ctx_o,
  output logic [rci_pkg::RootW-1:0] root_o
);

  localparam int N = rci_pkg::SqrtSteps;

  logic [N-1:0]                v_q;
  rci_pkg::ctx_t               ctx_q  [N];
  logic [rci_pkg::RadW-1:0]    rad_q  [N];
  logic [rci_pkg::RemW-1:0]    rem_q  [N];
  logic [rci_pkg::RootW-1:0]   root_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [rci_pkg::RadW-1:0]  rad_in;
    logic [rci_pkg::RemW-1:0]  rem_in, rem_sh, trial;
    logic [rci_pkg::RootW-1:0] root_in;
    rci_pkg::ctx_t             ctx_in;

    if (i == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign ctx_in  = ctx_i;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign ctx_in  = ctx_q[i-1];
    end

    assign rem_sh = {rem_in[rci_pkg::RemW-3:0], rad_in[rci_pkg::RadW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctx_q[i] <= ctx_in;
        rad_q[i] <= {rad_in[rci_pkg::RadW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q[i]  <= rem_sh - trial;
          root_q[i] <= {root_in[rci_pkg::RootW-2:0], 1'b1};
        end else begin
          rem_q[i]  <= rem_sh;
          root_q[i] <= {root_in[rci_pkg::RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign ctx_o   = ctx_q[N-1];
  assign root_o  = root_q[N-1];

endmodule

// File: rtl/rci_back.sv
// Back pipeline: crossing selection, point products, rounding, saturation and output register.
module rci_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  rci_pkg::ctx_t             ctx_i,
  input  logic [rci_pkg::RootW-1:0] root_i,
  output logic                      valid_o,
  output logic                      hit_o,
  output logic [31:0]               hit_distance_o,
  output logic signed [31:0]        hit_x_o,
  output logic signed [31:0]        hit_y_o,
  output logic [1:0]                where_is_o
);

  logic [2:0] v_q;
  logic signed [35:0] tn, tf;
  logic signed [35:0] t1_q;
  logic hit1_q, hit2_q, hit3_q;
  logic signed [31:0] px1_q, py1_q, px2_q, py2_q;
  logic signed [15:0] ux1_q, uy1_q;
  rci_pkg::where_e wh1_q, wh2_q, wh3_q;
  logic signed [51:0] mx2_q, my2_q;
  logic [31:0] dist2_q, dist3_q;
  logic signed [31:0] hx3_q, hy3_q;
  logic signed [36:0] rx, ry;

  assign tn = {ctx_i.dot[34], ctx_i.dot} - {5'd0, root_i};
  assign tf = {ctx_i.dot[34], ctx_i.dot} + {5'd0, root_i};
  assign rx = rci_pkg::round_pt(mx2_q);
  assign ry = rci_pkg::round_pt(my2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit1_q <= ctx_i.ok && ((tn > 36'sd0) || (tf > 36'sd0));
      t1_q   <= (tn > 36'sd0) ? tn : tf;
      px1_q  <= ctx_i.px;
      py1_q  <= ctx_i.py;
      ux1_q  <= ctx_i.ux;
      uy1_q  <= ctx_i.uy;
      wh1_q  <= ctx_i.where_is;

      hit2_q  <= hit1_q;
      px2_q   <= px1_q;
      py2_q   <= py1_q;
      wh2_q   <= wh1_q;
      mx2_q   <= ux1_q * t1_q;
      my2_q   <= uy1_q * t1_q;
      dist2_q <= (t1_q[35:32] != 4'd0) ? 32'hFFFFFFFF : t1_q[31:0];

      hit3_q  <= hit2_q;
      wh3_q   <= wh2_q;
      dist3_q <= hit2_q ? dist2_q : 32'd0;
      hx3_q   <= hit2_q ? rci_pkg::sat32({{6{px2_q[31]}}, px2_q} + {rx[36], rx}) : 32'sd0;
      hy3_q   <= hit2_q ? rci_pkg::sat32({{6{py2_q[31]}}, py2_q} + {ry[36], ry}) : 32'sd0;
    end
  end

  assign valid_o        = v_q[2];
  assign hit_o          = hit3_q;
  assign hit_distance_o = dist3_q;
  assign hit_x_o        = hx3_q;
  assign hit_y_o        = hy3_q;
  assign where_is_o     = wh3_q;

endmodule

// File: rtl/rci_checker.sv
// Port-level checker for the ray and circle intersection block and its bind.
module rci_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               hit_o,
  input logic [31:0]        hit_distance_o,
  input logic signed [31:0] hit_x_o,
  input logic signed [31:0] hit_y_o,
  input logic [1:0]         where_is_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_distance_o))
    else $error("Stalled result word changed.");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_distance_o == 32'd0 && hit_x_o == 32'sd0 && hit_y_o == 32'sd0)
    else $error("Miss word carries a nonzero distance or point.");

  a_hit_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> hit_distance_o != 32'd0)
    else $error("Hit word has zero distance.");

  a_where: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> where_is_o != 2'd3)
    else $error("Relation code out of range.");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("Input ready does not follow the output stall.");

endmodule

bind ray_circle_intersection rci_checker u_rci_checker (.*);

// File: tb/ray_circle_checker.sv
// Watches the ray and circle block's channels, predicts every result word and checks it.
`timescale 1ns / 100ps

module ray_circle_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               hit_i,
  input  logic [31:0]        hit_distance_i,
  input  logic signed [31:0] hit_x_i,
  input  logic signed [31:0] hit_y_i,
  input  logic [1:0]         where_is_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fails_o,
  output int                 pending_o,
  output int                 words_o,
  output int                 hits_o
);

  typedef struct {
    logic               hit;
    logic [31:0]        distance;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    rci_pkg::where_e    where_is;
  } crossing_t;

  crossing_t crossings_q[$];
  longint unsigned radius;
  longint center_x, center_y;

  function automatic longint round_q15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic crossing_t predict_crossing(longint px, longint py, longint ux, longint uy);
    crossing_t c;
    longint dx, dy, cr, dt, tn, tf, t;
    longint unsigned r2, ax, ay, s, cm, root;
    c.hit = 1'b0;
    c.distance = '0;
    c.hx = '0;
    c.hy = '0;
    dx = center_x - px;
    dy = center_y - py;
    r2 = radius * radius;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax >= 64'd2147483648 || ay >= 64'd2147483648) begin
      c.where_is = rci_pkg::WHERE_OUTSIDE;
    end else begin
      s = ax * ax + ay * ay;
      c.where_is = (s < r2) ? rci_pkg::WHERE_INSIDE :
                   (s > r2) ? rci_pkg::WHERE_OUTSIDE : rci_pkg::WHERE_ON;
    end
    cr = round_q15(ux * dy - uy * dx);
    cm = (cr < 0) ? -cr : cr;
    if (cm < radius) begin
      root = floor_sqrt(r2 - cm * cm);
      dt = round_q15(dx * ux + dy * uy);
      tn = dt - longint'(root);
      tf = dt + longint'(root);
      t = 0;
      if (tn > 0) begin
        t = tn;
        c.hit = 1'b1;
      end else if (tf > 0) begin
        t = tf;
        c.hit = 1'b1;
      end
      if (c.hit) begin
        c.distance = (t > 64'sd4294967295) ? 32'hFFFFFFFF : t[31:0];
        c.hx = 32'(clamp32(px + round_q15(ux * t)));
        c.hy = 32'(clamp32(py + round_q15(uy * t)));
      end
    end
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t e;
    if (!rst_ni) begin
      radius = 64'd65536;
      center_x = 0;
      center_y = 0;
      crossings_q.delete();
      fails_o = 0;
      words_o = 0;
      hits_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (rci_pkg::cfg_idx_e'(cfg_addr_i))
          rci_pkg::CFG_RADIUS:   radius = {33'd0, cfg_data_i[30:0]};
          rci_pkg::CFG_CENTER_X: center_x = longint'($signed(cfg_data_i));
          rci_pkg::CFG_CENTER_Y: center_y = longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        words_o++;
        if (crossings_q.size() == 0) begin
          fails_o++;
          $display("%0t: result word with nothing expected", $time);
        end else begin
          e = crossings_q.pop_front();
          if (e.hit) hits_o++;
          if (hit_i !== e.hit || hit_distance_i !== e.distance || hit_x_i !== e.hx ||
              hit_y_i !== e.hy || where_is_i !== e.where_is) begin
            fails_o++;
            $display("%0t: mismatch expected hit=%0b dist=%h x=%h y=%h where=%0d", $time,
                     e.hit, e.distance, e.hx, e.hy, e.where_is);
            $display("%0t:          actual   hit=%0b dist=%h x=%h y=%h where=%0d", $time,
                     hit_i, hit_distance_i, hit_x_i, hit_y_i, where_is_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        crossings_q.push_back(predict_crossing(longint'(pos_x_i), longint'(pos_y_i),
                                               longint'(dir_x_i), longint'(dir_y_i)));
      end
      pending_o = crossings_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the ray and circle testbench: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 100ps

module testbench;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_ready_o;
  logic signed [31:0] pos_x_i, pos_y_i;
  logic signed [15:0] dir_x_i, dir_y_i;
  logic               out_valid_o, out_ready_i;
  logic               hit_o;
  logic [31:0]        hit_distance_o;
  logic signed [31:0] hit_x_o, hit_y_o;
  logic [1:0]         where_is_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_addr_i;
  logic [31:0]        cfg_data_i;
  int                 fails, pending, words, hits, settings, cycles;
  logic               calm;
  longint unsigned    radius;
  longint             center_x, center_y;

  ray_circle_intersection i_dut (.*);

  ray_circle_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .pos_x_i, .pos_y_i, .dir_x_i,
    .dir_y_i, .out_valid_i(out_valid_o), .out_ready_i, .hit_i(hit_o),
    .hit_distance_i(hit_distance_o), .hit_x_i(hit_x_o), .hit_y_i(hit_y_o),
    .where_is_i(where_is_o), .cfg_we_i, .cfg_addr_i, .cfg_data_i, .fails_o(fails),
    .pending_o(pending), .words_o(words), .hits_o(hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic write_reg(rci_pkg::cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_circle(longint unsigned r, longint cx, longint cy);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    radius = r;
    center_x = cx;
    center_y = cy;
    write_reg(rci_pkg::CFG_RADIUS, 32'(r));
    write_reg(rci_pkg::CFG_CENTER_X, 32'(cx));
    write_reg(rci_pkg::CFG_CENTER_Y, 32'(cy));
    settings++;
  endtask

  task automatic send_ray(longint px, longint py, longint ux, longint uy);
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    pos_x_i = 32'(px);
    pos_y_i = 32'(py);
    dir_x_i = 16'(ux);
    dir_y_i = 16'(uy);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic random_rays(int n);
    longint span, ox, oy;
    real ang;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_ray(longint'($signed($urandom)), longint'($signed($urandom)),
                 longint'($signed(16'($urandom))), longint'($signed(16'($urandom))));
      end else begin
        span = 3 * longint'(radius) + 65536;
        ox = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
        oy = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
        ang = $urandom_range(0, 35999) * 6.283185307179586 / 36000.0;
        send_ray(clamp32(center_x + ox), clamp32(center_y + oy),
                 longint'($rtoi(32767.0 * $cos(ang))), longint'($rtoi(32767.0 * $sin(ang))));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    calm = 1'b0;
    in_valid_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    dir_x_i = '0;
    dir_y_i = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = rci_pkg::CFG_RADIUS;
    cfg_data_i = '0;
    radius = 65536;
    center_x = 0;
    center_y = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Unit circle at the origin straight after reset.
    send_ray(-2 * 65536, 0, 32767, 0);
    send_ray(-2 * 65536, 65536, 32767, 0);
    send_ray(-2 * 65536, 70000, 32767, 0);
    send_ray(2 * 65536, 0, 32767, 0);
    send_ray(0, 0, 0, -32768);
    send_ray(65536, 0, -32768, 0);
    send_ray(0, -65536, 0, 32767);
    send_ray(0, 0, 0, 0);
    send_ray(-65536, -65536, 23170, 23170);
    send_ray(-2147483648, -2147483648, 32767, 32767);
    send_ray(2147483647, 2147483647, -32768, -32768);
    send_ray(2147483647, 0, -32768, 0);
    send_ray(-2147483648, 0, 32767, 0);
    send_ray(0, 32768, -32768, 16384);
    send_ray(-1, -1, 32767, -32768);
    set_circle(64'd2147483647, 0, 0);
    send_ray(-2147483648, 0, 32767, 0);
    send_ray(0, -2147483648, 0, 32767);
    send_ray(2147483647, 2147483647, 0, 0);
    send_ray(2147483647, 2147483647, -32768, -32768);
    send_ray(2147483647, 0, -32768, 0);
    set_circle(64'd1000, -2147483648, 2147483647);
    send_ray(2147483647, -2147483648, -32768, 32767);
    send_ray(-2147483648, 2147483647, 0, -32768);
    send_ray(-2147483648 + 1000, 2147483647, 32767, 0);
    random_rays(60);

    set_circle(0, $signed($urandom_range(0, 65535)) << 8, -65536 * 7);
    random_rays(150);
    set_circle(64'd2147483647, $signed($urandom), $signed($urandom));
    random_rays(150);
    for (int k = 0; k < 5; k++) begin
      set_circle({$urandom_range(0, 40), 16'($urandom)}, longint'($signed($urandom)) >>> 4,
                 longint'($signed($urandom)) >>> 4);
      random_rays(220);
    end
    set_circle($urandom_range(0, 32'h7FFFFFFF), longint'($signed($urandom)),
               longint'($signed($urandom)));
    random_rays(120);
    calm = 1'b1;
    set_circle(3 * 65536 + 123, 65536 * 5, -65536 * 2);
    random_rays(200);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    $display("%0d result words checked under %0d circle settings, %0d of them hits",
             words, settings + 1, hits);
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d failures", fails);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rci_pkg.sv
rtl/rci_front.sv
rtl/rci_sqrt.sv
rtl/rci_back.sv
rtl/ray_circle_intersection.sv
rtl/rci_checker.sv
tb/ray_circle_checker.sv
tb/testbench.sv
